>>> sv/lfm_pkg.sv
package lfm_pkg;

  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int ML_W     = 17;
  localparam int MSQ_W    = 2 * ML_W;
  localparam int ENT_W    = 32;

  // normalized mantissa, sum of squares, root and quotient widths
  localparam int CM_W     = 31;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int Q_W      = 31;

  localparam int SQRT_ST  = ROOT_W / 2;
  localparam int DIV_ST   = 1 + (Q_W + 1) / 2;
  localparam int UNIT_LAT = 4 + SQRT_ST + DIV_ST;
  localparam int CROSS_LAT = 5;
  localparam int PIPE_LAT = CROSS_LAT + UNIT_LAT;

  // length test: magnitudes at or above 2^LB can never be short
  localparam int LB_XN    = 17;
  localparam int LB_Y     = 33;
  localparam int SH_XN    = 0;
  localparam int SH_Y     = 32;

  localparam logic [1:0]        ROW_LAST       = 2'd3;
  localparam logic [ENT_W-1:0]  ONE_Q16        = 32'h0001_0000;
  localparam logic [ML_W-1:0]   MIN_LENGTH_RST = 17'd1;
  localparam logic              REG_MIN_LENGTH = 1'b0;

endpackage

>>> sv/lfm_isqrt.sv
module lfm_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [lfm_pkg::SUM_W-1:0]  n_i,
  input  logic [TAG_W-1:0]           tag_i,
  output logic [lfm_pkg::ROOT_W-1:0] root_o,
  output logic [TAG_W-1:0]           tag_o
);
  import lfm_pkg::*;

  logic [ROOT_W+3:0]  rem_q  [SQRT_ST];
  logic [ROOT_W-1:0]  root_q [SQRT_ST];
  logic [SUM_W-1:0]   nb_q   [SQRT_ST];
  logic [TAG_W-1:0]   tag_q  [SQRT_ST];

  // two result bits per stage, digit-by-digit square root
  for (genvar s = 0; s < SQRT_ST; s++) begin : g_st
    logic [ROOT_W+3:0] rem_in, rem_d;
    logic [ROOT_W-1:0] root_in, root_d;
    logic [SUM_W-1:0]  nb_in, nb_d;
    logic [TAG_W-1:0]  tag_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign nb_in   = n_i;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign nb_in   = nb_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    always_comb begin
      logic [ROOT_W+3:0] trial;
      rem_d  = rem_in;
      root_d = root_in;
      nb_d   = nb_in;
      for (int k = 0; k < 2; k++) begin
        rem_d = {rem_d[ROOT_W+1:0], nb_d[SUM_W-1 -: 2]};
        nb_d  = nb_d << 2;
        trial = {2'b00, root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        nb_q[s]   <= nb_d;
        tag_q[s]  <= tag_in;
      end
    end
  end

  assign root_o = root_q[SQRT_ST-1];
  assign tag_o  = tag_q[SQRT_ST-1];

endmodule

>>> sv/lfm_div.sv
module lfm_div #(
  parameter int TAG_W = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [lfm_pkg::CM_W-1:0]   c_i,
  input  logic [lfm_pkg::ROOT_W-1:0] d_i,
  input  logic [TAG_W-1:0]           tag_i,
  output logic [lfm_pkg::Q_W-1:0]    q_o,
  output logic [TAG_W-1:0]           tag_o
);
  import lfm_pkg::*;

  localparam int NUM_W = CM_W + 31;

  logic [ROOT_W:0]   rem_q [DIV_ST];
  logic [Q_W-1:0]    nb_q  [DIV_ST];
  logic [Q_W-1:0]    q_q   [DIV_ST];
  logic [ROOT_W-1:0] d_q   [DIV_ST];
  logic [TAG_W-1:0]  tag_q [DIV_ST];

  // stage 0 forms c*2^30 + d/2 (round half up); then two quotient bits a stage, one in the last
  for (genvar s = 0; s < DIV_ST; s++) begin : g_st
    logic [ROOT_W:0]  rem_d;
    logic [Q_W-1:0]   nb_d;
    logic [Q_W-1:0]   q_d;

    if (s == 0) begin : g_prep
      always_comb begin
        logic [NUM_W-1:0] num;
        num   = {1'b0, c_i, 30'b0} + NUM_W'(d_i >> 1);
        rem_d = {2'b00, num[NUM_W-1:Q_W]};
        nb_d  = num[Q_W-1:0];
        q_d   = '0;
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          nb_q[s]  <= nb_d;
          q_q[s]   <= q_d;
          d_q[s]   <= d_i;
          tag_q[s] <= tag_i;
        end
      end
    end else begin : g_step
      always_comb begin
        rem_d = rem_q[s-1];
        nb_d  = nb_q[s-1];
        q_d   = q_q[s-1];
        for (int k = 0; k < 2; k++) begin
          if (2 * (s - 1) + k < Q_W) begin
            rem_d = {rem_d[ROOT_W-1:0], nb_d[Q_W-1]};
            nb_d  = nb_d << 1;
            if (rem_d >= {1'b0, d_q[s-1]}) begin
              rem_d = rem_d - {1'b0, d_q[s-1]};
              q_d   = {q_d[Q_W-2:0], 1'b1};
            end else begin
              q_d   = {q_d[Q_W-2:0], 1'b0};
            end
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          nb_q[s]  <= nb_d;
          q_q[s]   <= q_d;
          d_q[s]   <= d_q[s-1];
          tag_q[s] <= tag_q[s-1];
        end
      end
    end
  end

  assign q_o   = q_q[DIV_ST-1];
  assign tag_o = tag_q[DIV_ST-1];

endmodule

>>> sv/lfm_cross.sv
module lfm_cross #(
  parameter int CW = 32,
  localparam int MW = CW + 1,
  localparam int YW = 2 * MW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [CW-1:0] o_i  [3],
  input  logic [CW-1:0] a_i  [3],
  input  logic [CW-1:0] n_i  [3],
  output logic [MW-1:0] mx_o [3],
  output logic          sx_o [3],
  output logic [MW-1:0] mn_o [3],
  output logic          sn_o [3],
  output logic [YW-1:0] my_o [3],
  output logic          sy_o [3]
);
  import lfm_pkg::*;

  localparam int H   = (MW + 1) / 2;
  localparam int PPW = 2 * H;
  localparam int NDL = CROSS_LAT;

  // operand pairs of the six cross-product terms: y[j] = P[2j] - P[2j+1]
  localparam int NI [6] = '{1, 2, 2, 0, 0, 1};
  localparam int XI [6] = '{2, 1, 0, 2, 1, 0};

  logic [MW-1:0]  mx_q [NDL][3];
  logic           sx_q [NDL][3];
  logic [MW-1:0]  mn_q [NDL][3];
  logic           sn_q [NDL][3];

  logic [PPW-1:0] ll_q [6];
  logic [PPW-1:0] lh_q [6];
  logic [PPW-1:0] hl_q [6];
  logic [PPW-1:0] hh_q [6];
  logic           sp2_q [6];
  logic [YW-1:0]  pm_q [6];
  logic           sp3_q [6];
  logic [YW-1:0]  y_q  [3];
  logic [YW-1:0]  my_q [3];
  logic           sy_q [3];

  // stage 1: x = a - o, magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        logic [MW-1:0] xv, nv;
        xv = {a_i[i][CW-1], a_i[i]} - {o_i[i][CW-1], o_i[i]};
        nv = {n_i[i][CW-1], n_i[i]};
        mx_q[0][i] <= xv[MW-1] ? (~xv + 1'b1) : xv;
        sx_q[0][i] <= xv[MW-1];
        mn_q[0][i] <= nv[MW-1] ? (~nv + 1'b1) : nv;
        sn_q[0][i] <= nv[MW-1];
      end
    end
  end

  // x and n wait here until y leaves stage 5
  for (genvar s = 1; s < NDL; s++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mx_q[s] <= mx_q[s-1];
        sx_q[s] <= sx_q[s-1];
        mn_q[s] <= mn_q[s-1];
        sn_q[s] <= sn_q[s-1];
      end
    end
  end

  // stage 2: half-width partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        logic [H-1:0]    al, bl;
        logic [MW-H-1:0] ah, bh;
        al = mn_q[0][NI[k]][H-1:0];
        ah = mn_q[0][NI[k]][MW-1:H];
        bl = mx_q[0][XI[k]][H-1:0];
        bh = mx_q[0][XI[k]][MW-1:H];
        ll_q[k]  <= PPW'(al * bl);
        lh_q[k]  <= PPW'(al * bh);
        hl_q[k]  <= PPW'(ah * bl);
        hh_q[k]  <= PPW'(ah * bh);
        sp2_q[k] <= sn_q[0][NI[k]] ^ sx_q[0][XI[k]];
      end
    end
  end

  // stage 3: recombine partials
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        pm_q[k]  <= YW'(ll_q[k]) + ((YW'(lh_q[k]) + YW'(hl_q[k])) << H)
                    + (YW'(hh_q[k]) << (2 * H));
        sp3_q[k] <= sp2_q[k];
      end
    end
  end

  // stage 4: signed difference, stage 5: magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        logic [YW-1:0] va, vb;
        va = sp3_q[2*j]   ? (~pm_q[2*j]   + 1'b1) : pm_q[2*j];
        vb = sp3_q[2*j+1] ? (~pm_q[2*j+1] + 1'b1) : pm_q[2*j+1];
        y_q[j]  <= va - vb;
        my_q[j] <= y_q[j][YW-1] ? (~y_q[j] + 1'b1) : y_q[j];
        sy_q[j] <= y_q[j][YW-1];
      end
    end
  end

  assign mx_o = mx_q[NDL-1];
  assign sx_o = sx_q[NDL-1];
  assign mn_o = mn_q[NDL-1];
  assign sn_o = sn_q[NDL-1];
  assign my_o = my_q;
  assign sy_o = sy_q;

endmodule

>>> sv/lfm_unit.sv
module lfm_unit #(
  parameter int W  = 33,
  parameter int LB = 17,
  parameter int SH = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [lfm_pkg::MSQ_W-1:0] min_sq_i,
  input  logic [W-1:0]              mag_i [3],
  input  logic                      neg_i [3],
  output logic [lfm_pkg::ENT_W-1:0] u_o   [3],
  output logic                      degen_o
);
  import lfm_pkg::*;

  localparam int PW    = (W > 33) ? W : 33;
  localparam int LW    = $clog2(PW + 1);
  localparam int SQS_W = 2 * LB + 2;
  localparam int TAG_W = 1 + 3 + 3 * CM_W;

  logic [PW-1:0]     mag1_q [3];
  logic [2*LB-1:0]   sq1_q  [3];
  logic              neg1_q [3];
  logic              small1_q, zero1_q;
  logic [LW-1:0]     len1_q;

  logic [CM_W-1:0]   c2_q   [3];
  logic              neg2_q [3];
  logic              degen2_q;

  logic [2*CM_W-1:0] csq3_q [3];
  logic [CM_W-1:0]   c3_q   [3];
  logic              neg3_q [3];
  logic              degen3_q;

  logic [SUM_W-1:0]  sum4_q;
  logic [CM_W-1:0]   c4_q   [3];
  logic              neg4_q [3];
  logic              degen4_q;

  logic [TAG_W-1:0]  tag_in, tag_out;
  logic [ROOT_W-1:0] root, rdiv;
  logic [Q_W-1:0]    q      [3];
  logic [1:0]        dtag0;
  logic              dtag1, dtag2;

  // U1: short-length squares and leading-one position
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [PW-1:0] mp;
      logic [PW-1:0] orv;
      logic [LW-1:0] lenv;
      logic          sm, zr;
      orv = '0;
      sm  = 1'b1;
      zr  = 1'b1;
      for (int i = 0; i < 3; i++) begin
        mp  = PW'(mag_i[i]);
        orv = orv | mp;
        if ((mp >> LB) != '0) sm = 1'b0;
        if (mp != '0) zr = 1'b0;
        mag1_q[i] <= mp;
        sq1_q[i]  <= mp[LB-1:0] * mp[LB-1:0];
        neg1_q[i] <= neg_i[i];
      end
      lenv = '0;
      for (int b = 0; b < PW; b++) begin
        if (orv[b]) lenv = LW'(b + 1);
      end
      len1_q   <= lenv;
      small1_q <= sm;
      zero1_q  <= zr;
    end
  end

  // U2: length test, shift the largest component to exactly CM_W bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [SQS_W-1:0] ssum, thr;
      logic [PW-1:0]    shv;
      logic [LW-1:0]    shamt;
      ssum  = SQS_W'(sq1_q[0]) + SQS_W'(sq1_q[1]) + SQS_W'(sq1_q[2]);
      thr   = SQS_W'(min_sq_i) << SH;
      shamt = LW'(PW) - len1_q;
      for (int i = 0; i < 3; i++) begin
        shv       = mag1_q[i] << shamt;
        c2_q[i]   <= shv[PW-1 -: CM_W];
        neg2_q[i] <= neg1_q[i];
      end
      degen2_q <= zero1_q || (small1_q && (ssum < thr));
    end
  end

  // U3: squares, U4: sum of squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        csq3_q[i] <= c2_q[i] * c2_q[i];
        c3_q[i]   <= c2_q[i];
        neg3_q[i] <= neg2_q[i];
        c4_q[i]   <= c3_q[i];
        neg4_q[i] <= neg3_q[i];
      end
      degen3_q <= degen2_q;
      degen4_q <= degen3_q;
      sum4_q   <= SUM_W'(csq3_q[0]) + SUM_W'(csq3_q[1]) + SUM_W'(csq3_q[2]);
    end
  end

  assign tag_in = {degen4_q, neg4_q[0], neg4_q[1], neg4_q[2], c4_q[0], c4_q[1], c4_q[2]};

  lfm_isqrt #(.TAG_W(TAG_W)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .n_i    (sum4_q),
    .tag_i  (tag_in),
    .root_o (root),
    .tag_o  (tag_out)
  );

  // zero vector: keep the divisor nonzero, result is discarded anyway
  assign rdiv = (root == '0) ? ROOT_W'(1) : root;

  lfm_div #(.TAG_W(2)) u_div0 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .c_i   (tag_out[3*CM_W-1 -: CM_W]),
    .d_i   (rdiv),
    .tag_i ({tag_out[TAG_W-1], tag_out[TAG_W-2]}),
    .q_o   (q[0]),
    .tag_o (dtag0)
  );

  lfm_div #(.TAG_W(1)) u_div1 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .c_i   (tag_out[2*CM_W-1 -: CM_W]),
    .d_i   (rdiv),
    .tag_i (tag_out[TAG_W-3]),
    .q_o   (q[1]),
    .tag_o (dtag1)
  );

  lfm_div #(.TAG_W(1)) u_div2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .c_i   (tag_out[CM_W-1:0]),
    .d_i   (rdiv),
    .tag_i (tag_out[TAG_W-4]),
    .q_o   (q[2]),
    .tag_o (dtag2)
  );

  always_comb begin
    logic [ENT_W-1:0] qe [3];
    logic             ng [3];
    ng[0] = dtag0[0];
    ng[1] = dtag1;
    ng[2] = dtag2;
    for (int i = 0; i < 3; i++) begin
      qe[i]  = ENT_W'(q[i]);
      u_o[i] = ng[i] ? (~qe[i] + 1'b1) : qe[i];
    end
  end

  assign degen_o = dtag0[1];

endmodule

>>> sv/local_frame_matrix.sv
// Each item passes the cross-product, unit, square root and divider stages, and
// its rows leave the serializer on consecutive cycles while out_ready_i is high.
// Throughput: one item enters per cycle while in_ready_o is high; the four-row
// serializer (one row if degenerate) takes the next item as the last row leaves.
// Reset clears all valid bits and the output row state and sets min_length to 1.
module local_frame_matrix #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_WIDTH-1:0]        origin_x_i,
  input  logic [COORD_WIDTH-1:0]        origin_y_i,
  input  logic [COORD_WIDTH-1:0]        origin_z_i,
  input  logic [COORD_WIDTH-1:0]        axis_point_x_i,
  input  logic [COORD_WIDTH-1:0]        axis_point_y_i,
  input  logic [COORD_WIDTH-1:0]        axis_point_z_i,
  input  logic [COORD_WIDTH-1:0]        normal_x_i,
  input  logic [COORD_WIDTH-1:0]        normal_y_i,
  input  logic [COORD_WIDTH-1:0]        normal_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lfm_pkg::ENT_W-1:0]     entry0_o,
  output logic [lfm_pkg::ENT_W-1:0]     entry1_o,
  output logic [lfm_pkg::ENT_W-1:0]     entry2_o,
  output logic [lfm_pkg::ENT_W-1:0]     entry3_o,
  output logic [1:0]                    row_index_o,
  output logic                          status_o,
  output logic                          last_row_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfm_pkg::ADDR_W-1:0]    paddr,
  input  logic [lfm_pkg::DATA_W-1:0]    pwdata,
  output logic [lfm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import lfm_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int MW = CW + 1;
  localparam int YW = 2 * MW;

  logic [ML_W-1:0]   min_length_q;
  logic [MSQ_W-1:0]  min_sq_q;

  logic              en;
  logic [CW-1:0]     o_in [3];
  logic [CW-1:0]     a_in [3];
  logic [CW-1:0]     n_in [3];
  logic [MW-1:0]     mx [3];
  logic              sx [3];
  logic [MW-1:0]     mn [3];
  logic              sn [3];
  logic [YW-1:0]     my [3];
  logic              sy [3];
  logic [ENT_W-1:0]  ux [3];
  logic [ENT_W-1:0]  uy [3];
  logic [ENT_W-1:0]  un [3];
  logic              dgx, dgy, dgn;

  logic              vld_q [PIPE_LAT];
  logic [ENT_W-1:0]  org_q [PIPE_LAT][3];

  logic              busy_q, err_q;
  logic [1:0]        row_q;
  logic [ENT_W-1:0]  ux_q [3];
  logic [ENT_W-1:0]  uy_q [3];
  logic [ENT_W-1:0]  un_q [3];
  logic [ENT_W-1:0]  oq_q [3];
  logic              v_last, is_last, ser_free, load;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= MIN_LENGTH_RST;
      min_sq_q     <= MSQ_W'(1);
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_MIN_LENGTH) begin
        min_length_q <= pwdata[ML_W-1:0];
      end
      min_sq_q <= min_length_q * min_length_q;
    end
  end

  assign prdata = (paddr[2] == REG_MIN_LENGTH) ? DATA_W'(min_length_q) : '0;
  assign pready = 1'b1;

  assign o_in = '{origin_x_i, origin_y_i, origin_z_i};
  assign a_in = '{axis_point_x_i, axis_point_y_i, axis_point_z_i};
  assign n_in = '{normal_x_i, normal_y_i, normal_z_i};

  lfm_cross #(.CW(CW)) u_cross (
    .clk_i (clk_i),
    .en_i  (en),
    .o_i   (o_in),
    .a_i   (a_in),
    .n_i   (n_in),
    .mx_o  (mx),
    .sx_o  (sx),
    .mn_o  (mn),
    .sn_o  (sn),
    .my_o  (my),
    .sy_o  (sy)
  );

  lfm_unit #(.W(MW), .LB(LB_XN), .SH(SH_XN)) u_unit_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .min_sq_i (min_sq_q),
    .mag_i    (mx),
    .neg_i    (sx),
    .u_o      (ux),
    .degen_o  (dgx)
  );

  lfm_unit #(.W(YW), .LB(LB_Y), .SH(SH_Y)) u_unit_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .min_sq_i (min_sq_q),
    .mag_i    (my),
    .neg_i    (sy),
    .u_o      (uy),
    .degen_o  (dgy)
  );

  lfm_unit #(.W(MW), .LB(LB_XN), .SH(SH_XN)) u_unit_n (
    .clk_i    (clk_i),
    .en_i     (en),
    .min_sq_i (min_sq_q),
    .mag_i    (mn),
    .neg_i    (sn),
    .u_o      (un),
    .degen_o  (dgn)
  );

  // valid bits and origin travel beside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PIPE_LAT; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < PIPE_LAT; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [CW+ENT_W-1:0] ext;
        ext = {{ENT_W{o_in[i][CW-1]}}, o_in[i]};
        org_q[0][i] <= ext[ENT_W-1:0];
      end
      for (int s = 1; s < PIPE_LAT; s++) org_q[s] <= org_q[s-1];
    end
  end

  // row serializer
  assign v_last   = vld_q[PIPE_LAT-1];
  assign is_last  = err_q || (row_q == ROW_LAST);
  assign ser_free = !busy_q || (out_ready_i && is_last);
  assign en       = !v_last || ser_free;
  assign load     = en && v_last;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      err_q  <= 1'b0;
      row_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      err_q  <= dgx || dgy || dgn;
      row_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (is_last) busy_q <= 1'b0;
      else         row_q  <= row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ux_q <= ux;
      uy_q <= uy;
      un_q <= un;
      oq_q <= org_q[PIPE_LAT-1];
    end
  end

  always_comb begin
    entry0_o = '0;
    entry1_o = '0;
    entry2_o = '0;
    entry3_o = '0;
    if (!err_q) begin
      if (row_q == ROW_LAST) begin
        entry3_o = ONE_Q16;
      end else begin
        entry0_o = ux_q[row_q];
        entry1_o = uy_q[row_q];
        entry2_o = un_q[row_q];
        entry3_o = oq_q[row_q];
      end
    end
  end

  assign out_valid_o = busy_q;
  assign row_index_o = err_q ? 2'd0 : row_q;
  assign status_o    = err_q;
  assign last_row_o  = is_last;

  a_stall_holds_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !out_ready_i |=> busy_q && $stable(row_q))
    else $error("row changed while output stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v_last && busy_q)
    else $error("pipeline stalled without a waiting item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && busy_q |-> out_ready_i && is_last)
    else $error("matrix loaded over rows not yet delivered");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && err_q |-> last_row_o && row_index_o == 2'd0)
    else $error("degenerate item must give one final row");

endmodule
